>>> rtl/core/gpc_pkg.sv
// Shared constants, beat types and control structs for the grid path counter.
package gpc_pkg;

	localparam int MAX_DIM     = 128;
	localparam int COUNT_WIDTH = 32;
	localparam int IN_W        = 8;
	localparam int OUT_W       = 32;
	localparam int DIM_W       = $clog2(MAX_DIM + 1);
	localparam int IDX_W       = $clog2(MAX_DIM);

	typedef struct packed {
		logic [IN_W-1:0] rows;
		logic [IN_W-1:0] cols;
	} in_t;

	typedef struct packed {
		logic [OUT_W-1:0] path_count;
		logic             overflow;
	} out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic issue;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic trivial;
		logic last_issue;
	} status_t;

endpackage

>>> rtl/core/gpc_ctrl.sv
// Sequencer for the grid path counter: load, sweep the cells, drain, report.
module gpc_ctrl import gpc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  status_t status,
	output cmd_t    cmd,
	output logic    busy,
	output logic    done
);

	state_t state_q;
	state_t state_d;

	// Hold the state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Decide next state and drive commands.
	always_comb begin
		state_d   = state_q;
		cmd.load  = 1'b0;
		cmd.issue = 1'b0;
		busy      = 1'b1;
		done      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_d = status.trivial ? ST_DONE : ST_RUN;
			end
			ST_RUN: begin
				cmd.issue = 1'b1;
				if (status.last_issue) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/core/gpc_dp.sv
// Datapath: dimension registers, cell counters, row store and saturating adder.
module gpc_dp import gpc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	input  in_t     item,
	output status_t status,
	output out_t    result
);

	logic [COUNT_WIDTH-1:0] row_store [MAX_DIM];

	logic [DIM_W-1:0]       len_q;
	logic [DIM_W-1:0]       nrows_q;
	logic [IDX_W-1:0]       col_q;
	logic [DIM_W-1:0]       row_q;

	logic                   valid_s1;
	logic [IDX_W-1:0]       col_s1;
	logic                   first_s1;
	logic [COUNT_WIDTH-1:0] above_s1;

	logic [COUNT_WIDTH-1:0] left_q;
	logic [COUNT_WIDTH-1:0] res_q;
	logic                   sat_q;

	logic [DIM_W-1:0]       r_clamp;
	logic [DIM_W-1:0]       c_clamp;
	logic                   last_col;
	logic [COUNT_WIDTH-1:0] above;
	logic [COUNT_WIDTH-1:0] left;
	logic [COUNT_WIDTH:0]   sum;
	logic [COUNT_WIDTH-1:0] sat_sum;

	// Clamp incoming dimensions to the store depth.
	always_comb begin
		r_clamp = (DIM_W'(item.rows) > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(item.rows);
		c_clamp = (DIM_W'(item.cols) > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(item.cols);
	end

	assign last_col = (col_q == IDX_W'(len_q - DIM_W'(1)));

	assign status.trivial    = (len_q <= DIM_W'(1)) || (nrows_q <= DIM_W'(1));
	assign status.last_issue = last_col && (row_q == (nrows_q - DIM_W'(1)));

	// Capture dimensions, then advance the cell counters one cell per beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.load) begin
			col_q <= IDX_W'(1);
			row_q <= DIM_W'(1);
		end else if (cmd.issue) begin
			if (last_col) begin
				col_q <= IDX_W'(1);
				row_q <= row_q + DIM_W'(1);
			end else begin
				col_q <= col_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			len_q   <= (r_clamp < c_clamp) ? r_clamp : c_clamp;
			nrows_q <= (r_clamp < c_clamp) ? c_clamp : r_clamp;
		end
	end

	// Track the read stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
		end
	end

	always_ff @(posedge clk) begin
		col_s1   <= col_q;
		first_s1 <= (row_q == DIM_W'(1));
	end

	// Sum the cell above and the cell to the left, saturating at all ones.
	// The top row and the first column are implicitly one.
	always_comb begin
		above   = first_s1 ? COUNT_WIDTH'(1) : above_s1;
		left    = (col_s1 == IDX_W'(1)) ? COUNT_WIDTH'(1) : left_q;
		sum     = {1'b0, above} + {1'b0, left};
		sat_sum = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
	end

	// Write the new cell, read the next one; forward a same-address write.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			row_store[col_s1] <= sat_sum;
		end
		if (valid_s1 && (col_s1 == col_q)) begin
			above_s1 <= sat_sum;
		end else begin
			above_s1 <= row_store[col_q];
		end
	end

	// Hold the running left value, the last cell and the overflow flag.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_q <= ((r_clamp == '0) || (c_clamp == '0)) ? '0 : COUNT_WIDTH'(1);
			sat_q <= 1'b0;
		end else if (valid_s1) begin
			left_q <= sat_sum;
			res_q  <= sat_sum;
			sat_q  <= sat_q | sum[COUNT_WIDTH];
		end
	end

	assign result.path_count = OUT_W'(res_q);
	assign result.overflow   = sat_q;

endmodule

>>> rtl/core/grid_path_count.sv
// Top level of the grid path counter: controller plus datapath.
// Counts monotone right/down paths across a rows x cols grid with a one-row
// dynamic program, one cell addition per clock, the running row held in an
// internal row store with a registered read. An item goes from the start
// beat through load, a sweep of (max(r,c) - 1) * (min(r,c) - 1) cells and a
// drain to the done strobe, where r and c are the dimensions clamped to 128;
// a single-row, single-column or zero-dimension grid skips the sweep and
// drain. The single adder and one row store write port set the rate. Counts
// saturate at all ones and raise overflow. The result sits on result for the
// one cycle that done is high and must be taken then; busy stays high until
// that cycle is over, and start is ignored while busy.
module grid_path_count import gpc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  in_t  item,
	output logic busy,
	output logic done,
	output out_t result
);

	cmd_t    cmd;
	status_t status;

	gpc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	gpc_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.status (status),
		.result (result)
	);

endmodule
